// ----- rtl/core/ptw_pkg.sv -----
package ptw_pkg;

  localparam int TABLE_PAGES       = 8;
  localparam int ENTRIES_PER_TABLE = 512;
  localparam int MEM_WORDS         = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int ADDR_W            = $clog2(MEM_WORDS);
  localparam int PG_W              = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);

  localparam int WORD_W  = 64;
  localparam int WIDX_W  = 12;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int PPN_W   = 40;
  localparam int CFG_IDX_W = 1;

  localparam int IN_TDATA_W  = 128;
  localparam int OUT_TDATA_W = 320;

  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = QPTR_W + 1;

  localparam int BIT_PRESENT = 0;
  localparam int BIT_LARGE   = 7;

  typedef enum logic {
    OP_WRITE     = 1'b0,
    OP_TRANSLATE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROOT   = 1'b0,
    CFG_WINDOW = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WS_OK          = 2'd0,
    WS_NOT_PRESENT = 2'd1,
    WS_OUTSIDE     = 2'd2
  } walk_status_t;

  typedef enum logic [1:0] {
    PS_4K   = 2'd0,
    PS_2M   = 2'd1,
    PS_1G   = 2'd2,
    PS_NONE = 2'd3
  } page_size_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } walk_state_t;

  typedef struct packed {
    op_t               op;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;
    logic [VA_W-1:0]   virtual_address;
  } item_t;

  // front to back: head of the queue
  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  // back to front: dequeue and clearing status
  typedef struct packed {
    logic pop;
    logic clearing;
  } bk_t;

endpackage

// ----- rtl/core/ptw_ram.sv -----
module ptw_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/ptw_front.sv -----
module ptw_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [11:0] word_index, [75:12] word_data, [123:76] virtual_address, rest zero
  input  logic [ptw_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                             in_tuser,
  output ptw_pkg::fq_t                     fq,
  input  ptw_pkg::bk_t                     bk
);

  ptw_pkg::item_t              q_r [ptw_pkg::Q_DEPTH];
  logic [ptw_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [ptw_pkg::QCNT_W-1:0]  cnt_r, cnt_nxt;
  ptw_pkg::item_t              item;
  logic                        accept, keep, push, pop;

  always_comb begin
    item.op              = ptw_pkg::op_t'(in_tuser);
    item.word_index      = in_tdata[11:0];
    item.word_data       = in_tdata[75:12];
    item.virtual_address = in_tdata[123:76];
  end

  assign in_tready = (cnt_r != ptw_pkg::QCNT_W'(ptw_pkg::Q_DEPTH)) && !bk.clearing;
  assign accept    = in_tvalid && in_tready;
  // drop writes that land beyond the table memory
  assign keep      = (item.op == ptw_pkg::OP_TRANSLATE) ||
                     (32'(item.word_index) < ptw_pkg::MEM_WORDS);
  assign push      = accept && keep;
  assign pop       = bk.pop && (cnt_r != '0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

  assign fq.valid = (cnt_r != '0);
  assign fq.item  = q_r[rd_ptr_r];

endmodule

// ----- rtl/core/ptw_walker.sv -----
module ptw_walker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ptw_pkg::fq_t                       fq,
  output ptw_pkg::bk_t                       bk,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptw_pkg::PPN_W-1:0]          cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ptw_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  ptw_pkg::walk_state_t        state_r, state_nxt;
  logic [ptw_pkg::PPN_W-1:0]   root_r, base_r;
  logic [ptw_pkg::ADDR_W-1:0]  clr_r;
  logic [1:0]                  lvl_r;
  logic [ptw_pkg::PPN_W-1:0]   pg_r;
  logic [ptw_pkg::VA_W-1:0]    va_r;
  logic [ptw_pkg::WORD_W-1:0]  ent_r [4];
  logic                        mapped_r;
  logic [ptw_pkg::PA_W-1:0]    pa_r;
  ptw_pkg::page_size_t         size_r;
  ptw_pkg::walk_status_t       status_r;

  logic                        out_valid_r;
  logic                        o_mapped_r;
  logic [ptw_pkg::PA_W-1:0]    o_pa_r;
  logic [1:0]                  o_size_r, o_status_r;
  logic [ptw_pkg::WORD_W-1:0]  o_ent_r [4];

  logic                        ram_we;
  logic [ptw_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ptw_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  logic [ptw_pkg::PPN_W-1:0]   off;
  logic                        in_window;
  logic [ptw_pkg::IDX_W-1:0]   idx;
  logic                        clr_last;
  logic                        e_present, leaf_1g, leaf_2m, leaf_4k, walk_stop;
  logic                        out_free, load_out, pop;

  ptw_ram #(
    .WIDTH (ptw_pkg::WORD_W),
    .DEPTH (ptw_pkg::MEM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;

  // decode of the current level
  always_comb begin
    case (lvl_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
    off       = pg_r - base_r;
    in_window = (pg_r >= base_r) && (off < ptw_pkg::PPN_W'(ptw_pkg::TABLE_PAGES));
    clr_last  = (clr_r == ptw_pkg::ADDR_W'(ptw_pkg::MEM_WORDS - 1));
    e_present = ram_rdata[ptw_pkg::BIT_PRESENT];
    leaf_1g   = (lvl_r == 2'd1) && ram_rdata[ptw_pkg::BIT_LARGE];
    leaf_2m   = (lvl_r == 2'd2) && ram_rdata[ptw_pkg::BIT_LARGE];
    leaf_4k   = (lvl_r == 2'd3);
    walk_stop = !e_present || leaf_1g || leaf_2m || leaf_4k;
    out_free  = !out_valid_r || out_tready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptw_pkg::S_CLEAR: begin
        if (clr_last) begin
          state_nxt = ptw_pkg::S_IDLE;
        end
      end
      ptw_pkg::S_IDLE: begin
        if (fq.valid && fq.item.op == ptw_pkg::OP_TRANSLATE) begin
          state_nxt = ptw_pkg::S_READ;
        end
      end
      ptw_pkg::S_READ: begin
        state_nxt = in_window ? ptw_pkg::S_CHECK : ptw_pkg::S_DONE;
      end
      ptw_pkg::S_CHECK: begin
        state_nxt = walk_stop ? ptw_pkg::S_DONE : ptw_pkg::S_READ;
      end
      ptw_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = ptw_pkg::S_IDLE;
        end
      end
      default: state_nxt = ptw_pkg::S_CLEAR;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptw_pkg::ADDR_W'(fq.item.word_index);
    ram_wdata = fq.item.word_data;
    ram_raddr = ptw_pkg::ADDR_W'({off[ptw_pkg::PG_W-1:0], idx});
    pop       = 1'b0;
    load_out  = 1'b0;
    bk.clearing = 1'b0;
    case (state_r)
      ptw_pkg::S_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_r;
        ram_wdata   = '0;
        bk.clearing = 1'b1;
      end
      ptw_pkg::S_IDLE: begin
        pop    = fq.valid;
        ram_we = fq.valid && (fq.item.op == ptw_pkg::OP_WRITE);
      end
      ptw_pkg::S_DONE: begin
        load_out = out_free;
      end
      default: ;
    endcase
    bk.pop = pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ptw_pkg::S_CLEAR;
      clr_r       <= '0;
      root_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ptw_pkg::S_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        case (ptw_pkg::cfg_idx_t'(cfg_index))
          ptw_pkg::CFG_ROOT:   root_r <= cfg_data;
          ptw_pkg::CFG_WINDOW: base_r <= cfg_data;
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ptw_pkg::S_IDLE: begin
        if (pop && fq.item.op == ptw_pkg::OP_TRANSLATE) begin
          va_r     <= fq.item.virtual_address;
          pg_r     <= root_r;
          lvl_r    <= 2'd0;
          for (int i = 0; i < 4; i++) begin
            ent_r[i] <= '0;
          end
          mapped_r <= 1'b0;
          pa_r     <= '0;
          size_r   <= ptw_pkg::PS_NONE;
          status_r <= ptw_pkg::WS_OK;
        end
      end
      ptw_pkg::S_READ: begin
        if (!in_window) begin
          status_r <= ptw_pkg::WS_OUTSIDE;
        end
      end
      ptw_pkg::S_CHECK: begin
        ent_r[lvl_r] <= ram_rdata;
        if (!e_present) begin
          status_r <= ptw_pkg::WS_NOT_PRESENT;
        end else if (leaf_1g) begin
          mapped_r <= 1'b1;
          size_r   <= ptw_pkg::PS_1G;
          pa_r     <= {ram_rdata[51:30], va_r[29:0]};
        end else if (leaf_2m) begin
          mapped_r <= 1'b1;
          size_r   <= ptw_pkg::PS_2M;
          pa_r     <= {ram_rdata[51:21], va_r[20:0]};
        end else if (leaf_4k) begin
          mapped_r <= 1'b1;
          size_r   <= ptw_pkg::PS_4K;
          pa_r     <= {ram_rdata[51:12], va_r[11:0]};
        end else begin
          // advance to the next table
          pg_r  <= ram_rdata[51:12];
          lvl_r <= lvl_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      o_mapped_r <= mapped_r;
      o_pa_r     <= pa_r;
      o_size_r   <= size_r;
      o_status_r <= status_r;
      for (int i = 0; i < 4; i++) begin
        o_ent_r[i] <= ent_r[i];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, o_ent_r[3], o_ent_r[2], o_ent_r[1], o_ent_r[0],
                       o_status_r, o_size_r, o_pa_r, o_mapped_r};

endmodule

// ----- rtl/core/four_level_page_table_walker_core.sv -----
// With the walker idle, an accepted item waits in the input queue, then each table level
// is a registered read followed by a check (a table outside the window ends the walk after
// its read), and the result is loaded into the output register; out_tready low adds stalls.
// The walker works on one translate at a time while the input queue holds up to two more
// items; a write transaction is handled in the idle state. Reset is synchronous; a clearing
// pass then zeroes the 4096-word table memory with in_tready low (cfg writes are taken).
module four_level_page_table_walker_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [11:0] word_index, [75:12] word_data, [123:76] virtual_address, rest zero
  input  logic [ptw_pkg::IN_TDATA_W-1:0]     in_tdata,
  // [0] operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] mapped, [52:1] physical_address, [54:53] page_size, [56:55] walk_status,
  // [120:57] root_entry, [184:121] level3_entry, [248:185] level2_entry,
  // [312:249] level1_entry, rest zero
  output logic [ptw_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ptw_pkg::PPN_W-1:0]          cfg_data
);

  ptw_pkg::fq_t fq;
  ptw_pkg::bk_t bk;

  ptw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fq        (fq),
    .bk        (bk)
  );

  ptw_walker u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .fq         (fq),
    .bk         (bk),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- dv/ptw_walk_checker.sv -----
`timescale 1ns / 1ps
module ptw_walk_checker
  import ptw_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [PPN_W-1:0]       cfg_data,
  output int                     walk_failures,
  output int                     walks_pending
);

  typedef struct packed {
    logic              mapped;
    logic [PA_W-1:0]   xlat_addr;
    page_size_t        size;
    walk_status_t      status;
    logic [WORD_W-1:0] root_entry;
    logic [WORD_W-1:0] l3_entry;
    logic [WORD_W-1:0] l2_entry;
    logic [WORD_W-1:0] l1_entry;
  } walk_result_t;

  logic [WORD_W-1:0] shadow_tables [MEM_WORDS];
  logic [PPN_W-1:0]  root_page;
  logic [PPN_W-1:0]  window_page;
  walk_result_t      expected_walks [$];

  function automatic walk_result_t walk_tables(input logic [VA_W-1:0] va);
    walk_result_t      res;
    logic [PPN_W-1:0]  page;
    logic [PPN_W-1:0]  offs;
    logic [IDX_W-1:0]  slot;
    logic [WORD_W-1:0] pte;
    logic [WORD_W-1:0] seen [4];
    bit                done;
    int                lvl;
    res = '0;
    res.size = PS_NONE;
    res.status = WS_OK;
    seen = '{default: '0};
    page = root_page;
    done = 1'b0;
    for (lvl = 0; lvl < 4 && !done; lvl++) begin
      offs = page - window_page;
      if (page < window_page || offs >= TABLE_PAGES) begin
        res.status = WS_OUTSIDE;
        done = 1'b1;
      end else begin
        slot = va[39 - 9 * lvl +: IDX_W];
        pte = shadow_tables[{offs[PG_W-1:0], slot}];
        seen[lvl] = pte;
        if (!pte[BIT_PRESENT]) begin
          res.status = WS_NOT_PRESENT;
          done = 1'b1;
        end else if (lvl == 1 && pte[BIT_LARGE]) begin
          res.xlat_addr = {pte[51:30], va[29:0]};
          res.size = PS_1G;
          res.mapped = 1'b1;
          done = 1'b1;
        end else if (lvl == 2 && pte[BIT_LARGE]) begin
          res.xlat_addr = {pte[51:21], va[20:0]};
          res.size = PS_2M;
          res.mapped = 1'b1;
          done = 1'b1;
        end else if (lvl == 3) begin
          res.xlat_addr = {pte[51:12], va[11:0]};
          res.size = PS_4K;
          res.mapped = 1'b1;
          done = 1'b1;
        end else begin
          page = pte[51:12];
        end
      end
    end
    res.root_entry = seen[0];
    res.l3_entry = seen[1];
    res.l2_entry = seen[2];
    res.l1_entry = seen[3];
    return res;
  endfunction

  task automatic show_walk(input string tag, input walk_result_t w);
    $display("  %s mapped=%0b pa=%h size=%0d status=%0d", tag, w.mapped, w.xlat_addr,
             w.size, w.status);
    $display("  %s entries %h %h %h %h", tag, w.root_entry, w.l3_entry, w.l2_entry,
             w.l1_entry);
  endtask

  always @(posedge clk) begin
    walk_result_t got;
    walk_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < MEM_WORDS; i++) shadow_tables[i] = '0;
      root_page = '0;
      window_page = '0;
      expected_walks.delete();
      walk_failures = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ROOT:   root_page = cfg_data;
          CFG_WINDOW: window_page = cfg_data;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.mapped     = out_tdata[0];
        got.xlat_addr  = out_tdata[52:1];
        got.size       = page_size_t'(out_tdata[54:53]);
        got.status     = walk_status_t'(out_tdata[56:55]);
        got.root_entry = out_tdata[120:57];
        got.l3_entry   = out_tdata[184:121];
        got.l2_entry   = out_tdata[248:185];
        got.l1_entry   = out_tdata[312:249];
        if (expected_walks.size() == 0) begin
          walk_failures++;
          if (walk_failures <= 10) begin
            $display("%0t: result transaction with no translate pending", $realtime);
            show_walk("got", got);
          end
        end else begin
          want = expected_walks.pop_front();
          if (got !== want) begin
            walk_failures++;
            if (walk_failures <= 10) begin
              $display("%0t: walk result mismatch", $realtime);
              show_walk("exp", want);
              show_walk("got", got);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (op_t'(in_tuser) == OP_WRITE) begin
          shadow_tables[in_tdata[11:0]] = in_tdata[75:12];
        end else begin
          expected_walks.push_back(walk_tables(in_tdata[123:76]));
        end
      end
    end
    walks_pending <= expected_walks.size();
  end

endmodule

// ----- dv/four_level_page_table_walker_core_tb.sv -----
`timescale 1ns / 1ps
module four_level_page_table_walker_core_tb;
  import ptw_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 115;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [PPN_W-1:0]       cfg_data = '0;

  int               walk_failures;
  int               walks_pending;
  int               cycle_count = 0;
  int               items_sent = 0;
  logic             rx_hold_go = 1'b0;
  bit               sender_calm = 1'b0;
  logic [PPN_W-1:0] cur_root = '0;
  logic [PPN_W-1:0] cur_window = '0;
  logic [VA_W-1:0]  recent_vas [$];

  four_level_page_table_walker_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ptw_walk_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .walk_failures (walk_failures),
    .walks_pending (walks_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("four_level_page_table_walker_core_tb NOT OK");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // mostly short gaps, a few long ones
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic offer_item(input op_t op, input logic [WIDX_W-1:0] idx,
                            input logic [WORD_W-1:0] data, input logic [VA_W-1:0] va);
    int gap;
    gap = sender_calm ? 0 : idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {{(IN_TDATA_W - VA_W - WORD_W - WIDX_W){1'b0}}, va, data, idx};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  task automatic store_word(input logic [WIDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    offer_item(OP_WRITE, idx, data, VA_W'(rand64()));
  endtask

  task automatic translate(input logic [VA_W-1:0] va);
    offer_item(OP_TRANSLATE, WIDX_W'($urandom), rand64(), va);
  endtask

  // hold the input side until every walk has come back and the walker has gone quiet
  task automatic drain_walks();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (walks_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_walker(input logic [PPN_W-1:0] root, input logic [PPN_W-1:0] window);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_ROOT;
    cfg_data <= root;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_WINDOW;
    cfg_data <= window;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_root = root;
    cur_window = window;
  endtask

  // write the entries along the path of va, ending in a random leaf size;
  // now and then an entry is left not present or points outside the window
  task automatic map_address(input logic [VA_W-1:0] va);
    logic [PPN_W-1:0]  page;
    logic [PPN_W-1:0]  next_page;
    logic [PPN_W-1:0]  offs;
    logic [IDX_W-1:0]  slot;
    logic [WORD_W-1:0] pte;
    int                leaf_level;
    int                lvl;
    leaf_level = $urandom_range(1, 3);
    page = cur_root;
    for (lvl = 0; lvl <= leaf_level; lvl++) begin
      offs = page - cur_window;
      if (page < cur_window || offs >= TABLE_PAGES) break;
      slot = va[39 - 9 * lvl +: IDX_W];
      next_page = cur_window + PPN_W'($urandom_range(0, TABLE_PAGES - 1));
      if ($urandom_range(0, 24) == 0) next_page = PPN_W'(rand64());
      pte = rand64();
      pte[51:12] = next_page;
      pte[BIT_PRESENT] = ($urandom_range(0, 24) != 0);
      if (lvl == 1 || lvl == 2) pte[BIT_LARGE] = (lvl == leaf_level);
      store_word({offs[PG_W-1:0], slot}, pte);
      page = next_page;
    end
  endtask

  initial begin : receiver
    int gap;
    int run;
    bit hold_done;
    hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = idle_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [63:0]      rnd;
    logic [VA_W-1:0]  va;
    logic [PPN_W-1:0] window;
    logic [PPN_W-1:0] root;
    int               phase;
    int               phase_end;
    int               r;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    program_walker('0, '0);

    // empty tables: root entry not present
    translate('0);
    store_word(12'd5, 64'h0);
    store_word(12'd0, 64'h0000_0000_0000_1003);
    store_word(12'd512, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(48'h0000_3FFF_FFFF);
    translate(48'h0);
    store_word(12'd513, 64'h0000_0000_0000_2001);
    store_word(12'd1024, 64'h000A_BCDE_F020_0081);
    translate(48'h0000_401A_BCDE);
    store_word(12'd1025, 64'h0000_0000_0000_3001);
    store_word(12'd1536, 64'h8000_0123_4567_8081);
    translate(48'h0000_4020_0ABC);
    store_word(12'd1537, 64'hFFFF_FFFF_FFFF_FFFE);
    translate(48'h0000_4020_1000);
    // missing entries at the directory-pointer and directory levels
    translate(48'h0000_8000_0000);
    translate(48'h0000_4040_0000);
    // root entry points past the end of the window
    store_word(12'd1, 64'h0000_0000_0000_8001);
    translate(48'h0080_0000_0000);
    store_word(12'd511, 64'h0000_0000_0000_7001);
    store_word(12'd4095, 64'hFFFF_FFFF_FFFF_FFFF);
    translate(48'hFFFF_FFFF_FFFF);

    drain_walks();
    program_walker(40'd8, '0);
    translate(48'h0);

    // top of the page number range; the root entry loops back to its own page
    drain_walks();
    program_walker('1, '1);
    store_word(12'd0, {12'h000, 40'hFF_FFFF_FFFF, 12'h001});
    translate(48'h0);

    for (phase = 0; phase < PHASES; phase++) begin
      drain_walks();
      rnd = rand64();
      case (phase)
        0:       window = '0;
        2:       window = 40'hFF_FFFF_FFF8;
        4:       window = '1;
        default: window = rnd[PPN_W-1:0];
      endcase
      root = window + PPN_W'($urandom_range(0, TABLE_PAGES - 1));
      if (phase == 3) root = PPN_W'(rand64());
      if (phase == 4) root = window;
      program_walker(root, window);
      sender_calm = (phase == 5);
      if (phase == 1) rx_hold_go <= 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        r = $urandom_range(0, 99);
        rnd = rand64();
        if (r < 55) begin
          va = rnd[VA_W-1:0];
          map_address(va);
          translate(va);
          if ($urandom_range(0, 1)) translate({va[VA_W-1:12], 12'($urandom)});
          recent_vas.push_back(va);
          if (recent_vas.size() > 16) void'(recent_vas.pop_front());
        end else if (r < 75 && recent_vas.size() != 0) begin
          va = recent_vas[$urandom_range(0, recent_vas.size() - 1)];
          translate({va[VA_W-1:21], 21'($urandom)});
        end else if (r < 88) begin
          translate(rnd[VA_W-1:0]);
        end else begin
          store_word(12'($urandom), rand64());
        end
      end
    end

    drain_walks();
    if (walk_failures == 0 && walks_pending == 0) begin
      $display("four_level_page_table_walker_core_tb OK");
    end else begin
      $display("four_level_page_table_walker_core_tb NOT OK");
    end
    $finish;
  end

endmodule
